@@ src/assert_macros.svh @@
// Assertion helpers used by the top-level RTL; all sample on clk and stay quiet in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define ST_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define ST_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

@@ src/stok_pkg.sv @@
package stok_pkg;

	// Sizing
	localparam int KEYWORD_CHARS = 6;
	localparam int POSITION_BITS = 32;
	localparam int LENGTH_BITS   = 16;
	localparam int KIND_W        = 6;
	localparam int LINE_W        = 24;

	// Result queue
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	// Scanner modes
	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_NUM,
		MODE_IDENT,
		MODE_OP,
		MODE_ERR
	} mode_t;

	// Token kinds
	localparam logic [KIND_W-1:0] K_EOF    = 6'd0;
	localparam logic [KIND_W-1:0] K_NUM    = 6'd1;
	localparam logic [KIND_W-1:0] K_IDENT  = 6'd2;
	localparam logic [KIND_W-1:0] K_KW0    = 6'd3;
	localparam logic [KIND_W-1:0] K_LPAREN = 6'd12;
	localparam logic [KIND_W-1:0] K_RPAREN = 6'd13;
	localparam logic [KIND_W-1:0] K_PLUS   = 6'd14;
	localparam logic [KIND_W-1:0] K_MINUS  = 6'd15;
	localparam logic [KIND_W-1:0] K_STAR   = 6'd16;
	localparam logic [KIND_W-1:0] K_SLASH  = 6'd17;
	localparam logic [KIND_W-1:0] K_AMP    = 6'd18;
	localparam logic [KIND_W-1:0] K_ASSIGN = 6'd19;
	localparam logic [KIND_W-1:0] K_BANG   = 6'd21;
	localparam logic [KIND_W-1:0] K_LT     = 6'd23;
	localparam logic [KIND_W-1:0] K_GT     = 6'd25;
	localparam logic [KIND_W-1:0] K_SEMI   = 6'd27;
	localparam logic [KIND_W-1:0] K_COMMA  = 6'd28;
	localparam logic [KIND_W-1:0] K_LBRACK = 6'd29;
	localparam logic [KIND_W-1:0] K_RBRACK = 6'd30;
	localparam logic [KIND_W-1:0] K_LBRACE = 6'd31;
	localparam logic [KIND_W-1:0] K_RBRACE = 6'd32;
	localparam logic [KIND_W-1:0] K_ERROR  = 6'd33;

	// Source characters
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	// Keywords, left-justified and zero padded to the longest one
	localparam int KW_COUNT   = 9;
	localparam int KW_MAX_LEN = 6;
	localparam logic [KW_MAX_LEN*8-1:0] KW_TEXT [KW_COUNT] = '{
		"return",
		{"if", 32'h0},
		{"else", 16'h0},
		{"for", 24'h0},
		{"while", 8'h0},
		{"let", 24'h0},
		{"fn", 32'h0},
		{"true", 16'h0},
		{"false", 8'h0}
	};
	localparam logic [2:0] KW_LEN [KW_COUNT] = '{
		3'd6, 3'd2, 3'd4, 3'd3, 3'd5, 3'd3, 3'd2, 3'd4, 3'd5
	};

	// One result item
	typedef struct packed {
		logic [KIND_W-1:0]        kind;
		logic [LINE_W-1:0]        line;
		logic [POSITION_BITS-1:0] start;
		logic [LENGTH_BITS-1:0]   len;
		logic                     last;
	} result_t;

	// Results produced by one byte, lexer to queue
	typedef struct packed {
		logic [1:0] cnt;
		result_t    r0;
		result_t    r1;
	} push_t;

endpackage

@@ src/stok_lexer.sv @@
module stok_lexer
	import stok_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] byte_in,
	output push_t      push
);

	mode_t                          mode_q, mode_d;
	logic [KIND_W-1:0]              pend_q, pend_d;
	logic [KEYWORD_CHARS-1:0][7:0]  kwbuf_q, kwbuf_d;
	logic [POSITION_BITS-1:0]       start_q, start_d;
	logic [LENGTH_BITS-1:0]         len_q, len_d;
	logic [POSITION_BITS-1:0]       pos_q, pos_d;
	logic [LINE_W-1:0]              line_q, line_d;

	logic                           fl_v, nw_v, consumed, is_dig, is_alp;
	logic [KIND_W-1:0]              fl_kind, nw_kind;
	logic [POSITION_BITS-1:0]       fl_start, nw_start;
	logic [LENGTH_BITS-1:0]         fl_len, nw_len, len_inc;

	function automatic logic [KIND_W-1:0] single_kind(input logic [7:0] b);
		logic [KIND_W-1:0] k;
		unique case (b)
			CH_LPAREN: k = K_LPAREN;
			CH_RPAREN: k = K_RPAREN;
			CH_PLUS:   k = K_PLUS;
			CH_MINUS:  k = K_MINUS;
			CH_STAR:   k = K_STAR;
			CH_SLASH:  k = K_SLASH;
			CH_AMP:    k = K_AMP;
			CH_SEMI:   k = K_SEMI;
			CH_COMMA:  k = K_COMMA;
			CH_LBRACK: k = K_LBRACK;
			CH_RBRACK: k = K_RBRACK;
			CH_LBRACE: k = K_LBRACE;
			CH_RBRACE: k = K_RBRACE;
			default:   k = K_ERROR;
		endcase
		return k;
	endfunction

	// Bytes past the length are zero in both buffer and table, so a full compare works
	function automatic logic [KIND_W-1:0] ident_kind(
		input logic [KEYWORD_CHARS-1:0][7:0] kw_buf,
		input logic [LENGTH_BITS-1:0]        len
	);
		logic [KIND_W-1:0] k;
		logic              hit;
		k = K_IDENT;
		for (int i = KW_COUNT - 1; i >= 0; i--) begin
			hit = (len == LENGTH_BITS'(KW_LEN[i]));
			for (int j = 0; j < KW_MAX_LEN; j++) begin
				if (kw_buf[j] != KW_TEXT[i][(KW_MAX_LEN-1-j)*8 +: 8]) begin
					hit = 1'b0;
				end
			end
			if (hit) begin
				k = K_KW0 + KIND_W'(i);
			end
		end
		return k;
	endfunction

	assign is_dig  = (byte_in >= "0") && (byte_in <= "9");
	assign is_alp  = ((byte_in >= "a") && (byte_in <= "z")) ||
		((byte_in >= "A") && (byte_in <= "Z"));
	assign len_inc = (len_q != '1) ? len_q + LENGTH_BITS'(1) : len_q;

	// Scan one byte: close the running token, then start or emit a new one
	always_comb begin
		mode_d   = mode_q;
		pend_d   = pend_q;
		kwbuf_d  = kwbuf_q;
		start_d  = start_q;
		len_d    = len_q;
		pos_d    = pos_q + POSITION_BITS'(1);
		line_d   = line_q;
		consumed = 1'b0;
		fl_v     = 1'b0;
		fl_kind  = K_EOF;
		fl_start = start_q;
		fl_len   = len_q;
		nw_v     = 1'b0;
		nw_kind  = K_EOF;
		nw_start = pos_q;
		nw_len   = LENGTH_BITS'(1);

		unique case (mode_q)
			MODE_NUM: begin
				if (is_dig) begin
					len_d    = len_inc;
					consumed = 1'b1;
				end else begin
					fl_v    = 1'b1;
					fl_kind = K_NUM;
					mode_d  = MODE_IDLE;
				end
			end
			MODE_IDENT: begin
				if (is_dig || is_alp) begin
					for (int j = 0; j < KEYWORD_CHARS; j++) begin
						if (len_q == LENGTH_BITS'(j)) begin
							kwbuf_d[j] = byte_in;
						end
					end
					len_d    = len_inc;
					consumed = 1'b1;
				end else begin
					fl_v    = 1'b1;
					fl_kind = (len_q > LENGTH_BITS'(KEYWORD_CHARS)) ? K_IDENT :
						ident_kind(kwbuf_q, len_q);
					mode_d  = MODE_IDLE;
				end
			end
			MODE_OP: begin
				fl_v = 1'b1;
				if (byte_in == CH_EQ) begin
					fl_kind  = pend_q + KIND_W'(1);
					fl_len   = LENGTH_BITS'(2);
					consumed = 1'b1;
				end else begin
					fl_kind = pend_q;
					fl_len  = LENGTH_BITS'(1);
				end
				mode_d = MODE_IDLE;
				pend_d = '0;
			end
			MODE_ERR: begin
				// silent until reset
				consumed = 1'b1;
				pos_d    = pos_q;
			end
			default: begin
				mode_d = MODE_IDLE;
			end
		endcase

		if (!consumed) begin
			priority if (byte_in == CH_SPACE || byte_in == CH_CR || byte_in == CH_TAB) begin
				// skip whitespace
			end else if (byte_in == CH_LF) begin
				if (line_q != '1) begin
					line_d = line_q + LINE_W'(1);
				end
			end else if (byte_in == CH_NUL) begin
				nw_v    = 1'b1;
				nw_kind = K_EOF;
				nw_len  = '0;
				mode_d  = MODE_IDLE;
				pend_d  = '0;
				kwbuf_d = '0;
				start_d = '0;
				len_d   = '0;
				pos_d   = '0;
				line_d  = LINE_W'(1);
			end else if (is_dig) begin
				mode_d  = MODE_NUM;
				start_d = pos_q;
				len_d   = LENGTH_BITS'(1);
			end else if (is_alp) begin
				mode_d     = MODE_IDENT;
				start_d    = pos_q;
				len_d      = LENGTH_BITS'(1);
				kwbuf_d    = '0;
				kwbuf_d[0] = byte_in;
			end else if (byte_in == CH_EQ || byte_in == CH_BANG ||
					byte_in == CH_LT || byte_in == CH_GT) begin
				mode_d  = MODE_OP;
				start_d = pos_q;
				len_d   = LENGTH_BITS'(1);
				pend_d  = (byte_in == CH_EQ) ? K_ASSIGN : (byte_in == CH_BANG) ? K_BANG :
					(byte_in == CH_LT) ? K_LT : K_GT;
			end else begin
				nw_v    = 1'b1;
				nw_kind = single_kind(byte_in);
				if (nw_kind == K_ERROR) begin
					mode_d = MODE_ERR;
				end
			end
		end
	end

	// Pack the results of this byte in order, flush first
	always_comb begin
		push.cnt      = step ? (2'(fl_v) + 2'(nw_v)) : 2'd0;
		push.r0.kind  = fl_v ? fl_kind : nw_kind;
		push.r0.line  = line_q;
		push.r0.start = fl_v ? fl_start : nw_start;
		push.r0.len   = fl_v ? fl_len : nw_len;
		push.r0.last  = !(fl_v && nw_v);
		push.r1.kind  = nw_kind;
		push.r1.line  = line_q;
		push.r1.start = nw_start;
		push.r1.len   = nw_len;
		push.r1.last  = 1'b1;
	end

	// Advance scanner state on each processed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			pend_q  <= '0;
			kwbuf_q <= '0;
			start_q <= '0;
			len_q   <= '0;
			pos_q   <= '0;
			line_q  <= LINE_W'(1);
		end else if (step) begin
			mode_q  <= mode_d;
			pend_q  <= pend_d;
			kwbuf_q <= kwbuf_d;
			start_q <= start_d;
			len_q   <= len_d;
			pos_q   <= pos_d;
			line_q  <= line_d;
		end
	end

endmodule

@@ src/stok_fifo.sv @@
module stok_fifo
	import stok_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  push_t              push,
	input  logic               pop,
	output result_t            head,
	output logic [FIFO_AW:0]   count
);

	result_t              mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   head_q, tail_q;
	logic [FIFO_AW:0]     count_q;

	assign head  = mem_q[head_q];
	assign count = count_q;

	// Write up to two results per cycle
	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem_q[tail_q] <= push.r0;
		end
		if (push.cnt == 2'd2) begin
			mem_q[tail_q + FIFO_AW'(1)] <= push.r1;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			tail_q  <= tail_q + FIFO_AW'(push.cnt);
			head_q  <= head_q + FIFO_AW'(pop);
			count_q <= count_q + (FIFO_AW+1)'(push.cnt) - (FIFO_AW+1)'(pop);
		end
	end

endmodule

@@ src/source_tokenizer.sv @@
// A taken byte is held in byte_s1, then scanned; its tokens go to the result queue.
// Throughput: one byte per cycle unless stalled; two tokens of one byte leave in turn.
// The input stalls while the four-entry result queue holds more than two tokens.
// Reset (arst_n low, asynchronous): scanner idle, line 1, offset 0, queue empty.
`include "assert_macros.svh"

module source_tokenizer
	import stok_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [7:0]               source_byte,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [KIND_W-1:0]        token_kind,
	output logic [LINE_W-1:0]        line_number,
	output logic [POSITION_BITS-1:0] start_offset,
	output logic [LENGTH_BITS-1:0]   token_length,
	output logic                     last_of_run
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             advance;
	logic             pop;
	push_t            push;
	result_t          head;
	logic [FIFO_AW:0] count;

	// Scan the held byte when the queue has room for two tokens
	assign advance  = valid_s1 && (count <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
	assign in_stall = valid_s1 && !advance;
	assign pop      = out_valid && !out_stall;

	// Hold the input byte until scanned
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= source_byte;
		end
	end

	stok_lexer u_lexer (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.byte_in (byte_s1),
		.push    (push)
	);

	stok_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.count  (count)
	);

	// Drive the output transfer from the queue head
	assign out_valid    = (count != '0);
	assign token_kind   = head.kind;
	assign line_number  = head.line;
	assign start_offset = head.start;
	assign token_length = head.len;
	assign last_of_run  = head.last;

	`ST_ASSERT(a_fifo_bound, count <= (FIFO_AW+1)'(FIFO_DEPTH), "result queue overflow")
	`ST_ASSERT_IMPL(a_pair_whole, out_valid && !last_of_run, count >= (FIFO_AW+1)'(2), "token pair split in queue")
	`ST_ASSERT_IMPL(a_eof_last, out_valid && token_kind == K_EOF, last_of_run, "eof not last of its byte")
	`ST_ASSERT_IMPL(a_stall_held, in_stall, valid_s1 && count > (FIFO_AW+1)'(FIFO_DEPTH - 2), "stall without held byte")

endmodule
